FILE: sv/kcrt_pkg.sv
// Shared types, sizes and helpers for the keyed count ranking table.
// Used by keyed_count_ranking_table_core and the testbench by scoped names.
`default_nettype none
package kcrt_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int BUCKETS       = 2048;
	localparam int BOARD_BYTES   = 18;

	localparam int ENTRY_AW  = $clog2(TABLE_ENTRIES);
	localparam int PTR_W     = ENTRY_AW + 1;
	localparam int BUCKET_AW = $clog2(BUCKETS);

	localparam logic [PTR_W-1:0] PTR_EMPTY = PTR_W'(TABLE_ENTRIES);

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_RANK = 2'd1,
		STAT_FULL = 2'd2,
		STAT_SAT  = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_HEAD, ST_HEADW, ST_WALK, ST_CMP, ST_POSW, ST_NEW,
		ST_LINK, ST_PRD, ST_PCMP, ST_PFIN, ST_RCHK, ST_RRANK, ST_RENT, ST_CLEAR,
		ST_OUT
	} state_t;

	// entry word, thread id in the low bits
	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] post_time;
		logic [31:0] count;
		logic [47:0] board_low;
		logic [47:0] board_mid;
		logic [47:0] board_high;
		logic [30:0] thread;
	} entry_t;

	typedef struct packed {
		logic [31:0]         count;
		logic [ENTRY_AW-1:0] entry;
	} rank_word_t;

	typedef struct packed {
		logic                 entry_we;
		logic [ENTRY_AW-1:0]  entry_waddr;
		entry_t               entry_wdata;
		logic                 next_we;
		logic [ENTRY_AW-1:0]  next_waddr;
		logic [PTR_W-1:0]     next_wdata;
		logic                 head_we;
		logic [BUCKET_AW-1:0] head_waddr;
		logic [PTR_W-1:0]     head_wdata;
		logic                 rank_we;
		logic [ENTRY_AW-1:0]  rank_waddr;
		rank_word_t           rank_wdata;
		logic                 pos_we;
		logic [ENTRY_AW-1:0]  pos_waddr;
		logic [ENTRY_AW-1:0]  pos_wdata;
	} mem_wr_t;

	// byte 0 of each word sits in bits 47..40
	function automatic logic [47:0] board_mask(input int unsigned word);
		logic [47:0] m;
		m = '0;
		for (int unsigned b = 0; b < 6; b++) begin
			if (word * 6 + b < BOARD_BYTES)
				m[47 - 8 * b -: 8] = 8'hFF;
		end
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: sv/keyed_count_ranking_table_core.sv
// Keyed post-count ranking table: hash chains, rank list and FSM.
// Depends on kcrt_pkg and kcrt_ram.
//
// Input words arrive on s_tvalid/s_tready/s_tdata and each gives exactly
// one result word on m_tvalid/m_tready/m_tdata. cfg_valid/cfg_data write
// top_limit at any time the block is idle; cfg_ready is always high.
// One item is in work at a time; s_tready is high only in the idle state.
// Work per item (accept to next accept), all paced by the registered read
// data of the RAMs:
//   add hit: grows with chain entries visited and ranks moved
//   add new: as add hit, plus writing and linking the new entry
//   add to a full table: grows with chain entries visited only
//   read: rank check, rank word, entry; rank check only when out of range
//   clear: one bucket head rewritten per cycle; opcode 3: straight to the result
// After reset all 2048 bucket heads are swept to empty before the first
// word is accepted; config writes are taken during that time.
// A finished result sits in the output register; a stalled receiver only
// holds the next item in its final state until the register frees.
`default_nettype none
module keyed_count_ranking_table_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// opcode, thread_id, board_key_high, board_key_mid, board_key_low,
	// post_count, post_time, payload_tag, rank_index
	input  wire logic [255:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status, out_thread_id, out_board_high, out_board_mid, out_board_low,
	// out_count, out_time, out_tag, out_rank
	output logic      [271:0] m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [8:0]   cfg_data
);

	localparam int EAW = kcrt_pkg::ENTRY_AW;
	localparam int PW  = kcrt_pkg::PTR_W;
	localparam int BAW = kcrt_pkg::BUCKET_AW;

	kcrt_pkg::state_t state_q, state_d;
	kcrt_pkg::mem_wr_t wr;

	logic [30:0]  tid_q;
	logic [47:0]  bh_q, bm_q, bl_q;
	logic [15:0]  cnt_q;
	logic [31:0]  tm_q;
	logic [15:0]  tag_q;
	logic [7:0]   ri_q;
	logic [PW-1:0] cur_q, tail_q, steps_q, used_q;
	logic [EAW-1:0] p_q, e_q;
	logic [31:0]  ecount_q;
	kcrt_pkg::entry_t ent_q;
	logic [1:0]   st_q;
	logic [7:0]   rank_q;
	logic [BAW-1:0] sweep_q;
	logic [8:0]   top_limit_q;
	logic         m_tvalid_q;
	logic [271:0] m_tdata_q;

	kcrt_pkg::entry_t entry_rdata;
	kcrt_pkg::rank_word_t rank_rdata;
	logic [PW-1:0] next_rdata, head_rdata;
	logic [EAW-1:0] pos_rdata;
	logic [EAW-1:0] entry_raddr, rank_raddr;

	logic in_acc, match, chain_end, table_full, read_ok, load_out;
	logic [32:0] sum;
	kcrt_pkg::entry_t hit_ent, new_ent;

	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = (state_q == kcrt_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign load_out  = (state_q == kcrt_pkg::ST_OUT) && (!m_tvalid_q || m_tready);

	assign match = (entry_rdata.thread == tid_q) && (entry_rdata.board_high == bh_q) &&
		(entry_rdata.board_mid == bm_q) && (entry_rdata.board_low == bl_q);
	assign chain_end  = cur_q[PW-1] || steps_q[PW-1];
	assign table_full = (used_q == kcrt_pkg::PTR_EMPTY);
	assign read_ok    = ({1'b0, ri_q} < top_limit_q) && ({1'b0, ri_q} < used_q);
	assign sum        = {1'b0, entry_rdata.count} + {17'd0, cnt_q};

	always_comb begin
		hit_ent = entry_rdata;
		hit_ent.count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		if (tm_q > entry_rdata.post_time)
			hit_ent.post_time = tm_q;
		new_ent.thread     = tid_q;
		new_ent.board_high = bh_q;
		new_ent.board_mid  = bm_q;
		new_ent.board_low  = bl_q;
		new_ent.count      = {16'd0, cnt_q};
		new_ent.post_time  = tm_q;
		new_ent.tag        = tag_q;
	end

	assign entry_raddr = (state_q == kcrt_pkg::ST_RRANK) ? rank_rdata.entry : cur_q[EAW-1:0];
	assign rank_raddr  = (state_q == kcrt_pkg::ST_RCHK) ? ri_q[EAW-1:0] : EAW'(p_q - 1'b1);

	kcrt_ram #(.WIDTH($bits(kcrt_pkg::entry_t)), .DEPTH(kcrt_pkg::TABLE_ENTRIES)) u_entry_ram (
		.clk(clk), .we(wr.entry_we), .waddr(wr.entry_waddr), .wdata(wr.entry_wdata),
		.raddr(entry_raddr), .rdata(entry_rdata)
	);
	kcrt_ram #(.WIDTH(PW), .DEPTH(kcrt_pkg::TABLE_ENTRIES)) u_next_ram (
		.clk(clk), .we(wr.next_we), .waddr(wr.next_waddr), .wdata(wr.next_wdata),
		.raddr(cur_q[EAW-1:0]), .rdata(next_rdata)
	);
	kcrt_ram #(.WIDTH(PW), .DEPTH(kcrt_pkg::BUCKETS)) u_head_ram (
		.clk(clk), .we(wr.head_we), .waddr(wr.head_waddr), .wdata(wr.head_wdata),
		.raddr(tid_q[BAW-1:0]), .rdata(head_rdata)
	);
	kcrt_ram #(.WIDTH($bits(kcrt_pkg::rank_word_t)), .DEPTH(kcrt_pkg::TABLE_ENTRIES)) u_rank_ram (
		.clk(clk), .we(wr.rank_we), .waddr(wr.rank_waddr), .wdata(wr.rank_wdata),
		.raddr(rank_raddr), .rdata(rank_rdata)
	);
	kcrt_ram #(.WIDTH(EAW), .DEPTH(kcrt_pkg::TABLE_ENTRIES)) u_pos_ram (
		.clk(clk), .we(wr.pos_we), .waddr(wr.pos_waddr), .wdata(wr.pos_wdata),
		.raddr(cur_q[EAW-1:0]), .rdata(pos_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kcrt_pkg::ST_INIT:  if (sweep_q == BAW'(kcrt_pkg::BUCKETS - 1)) state_d = kcrt_pkg::ST_IDLE;
			kcrt_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					case (kcrt_pkg::opcode_t'(s_tdata[1:0]))
						kcrt_pkg::OP_ADD:   state_d = kcrt_pkg::ST_HEAD;
						kcrt_pkg::OP_READ:  state_d = kcrt_pkg::ST_RCHK;
						kcrt_pkg::OP_CLEAR: state_d = kcrt_pkg::ST_CLEAR;
						default:            state_d = kcrt_pkg::ST_OUT;
					endcase
				end
			end
			kcrt_pkg::ST_HEAD:  state_d = kcrt_pkg::ST_HEADW;
			kcrt_pkg::ST_HEADW: state_d = kcrt_pkg::ST_WALK;
			kcrt_pkg::ST_WALK: begin
				if (!chain_end)
					state_d = kcrt_pkg::ST_CMP;
				else if (table_full)
					state_d = kcrt_pkg::ST_OUT;
				else
					state_d = kcrt_pkg::ST_NEW;
			end
			kcrt_pkg::ST_CMP:   state_d = match ? kcrt_pkg::ST_POSW : kcrt_pkg::ST_WALK;
			kcrt_pkg::ST_POSW:  state_d = kcrt_pkg::ST_PRD;
			kcrt_pkg::ST_NEW:   state_d = kcrt_pkg::ST_LINK;
			kcrt_pkg::ST_LINK:  state_d = kcrt_pkg::ST_PRD;
			kcrt_pkg::ST_PRD:   state_d = (p_q == '0) ? kcrt_pkg::ST_PFIN : kcrt_pkg::ST_PCMP;
			kcrt_pkg::ST_PCMP:
				state_d = (rank_rdata.count < ecount_q) ? kcrt_pkg::ST_PRD : kcrt_pkg::ST_PFIN;
			kcrt_pkg::ST_PFIN:  state_d = kcrt_pkg::ST_OUT;
			kcrt_pkg::ST_RCHK:  state_d = read_ok ? kcrt_pkg::ST_RRANK : kcrt_pkg::ST_OUT;
			kcrt_pkg::ST_RRANK: state_d = kcrt_pkg::ST_RENT;
			kcrt_pkg::ST_RENT:  state_d = kcrt_pkg::ST_OUT;
			kcrt_pkg::ST_CLEAR:
				if (sweep_q == BAW'(kcrt_pkg::BUCKETS - 1)) state_d = kcrt_pkg::ST_OUT;
			kcrt_pkg::ST_OUT:   if (load_out) state_d = kcrt_pkg::ST_IDLE;
			default:            state_d = kcrt_pkg::ST_IDLE;
		endcase
	end

	// memory writes
	always_comb begin
		wr = '0;
		wr.head_waddr = tid_q[BAW-1:0];
		wr.head_wdata = kcrt_pkg::PTR_EMPTY;
		unique case (state_q)
			kcrt_pkg::ST_INIT, kcrt_pkg::ST_CLEAR: begin
				wr.head_we    = 1'b1;
				wr.head_waddr = sweep_q;
			end
			kcrt_pkg::ST_CMP: begin
				wr.entry_we    = match;
				wr.entry_waddr = cur_q[EAW-1:0];
				wr.entry_wdata = hit_ent;
			end
			kcrt_pkg::ST_NEW: begin
				wr.entry_we         = 1'b1;
				wr.entry_waddr      = used_q[EAW-1:0];
				wr.entry_wdata      = new_ent;
				wr.next_we          = 1'b1;
				wr.next_waddr       = used_q[EAW-1:0];
				wr.next_wdata       = kcrt_pkg::PTR_EMPTY;
				wr.rank_we          = 1'b1;
				wr.rank_waddr       = used_q[EAW-1:0];
				wr.rank_wdata.entry = used_q[EAW-1:0];
				wr.rank_wdata.count = {16'd0, cnt_q};
				wr.pos_we           = 1'b1;
				wr.pos_waddr        = used_q[EAW-1:0];
				wr.pos_wdata        = used_q[EAW-1:0];
			end
			kcrt_pkg::ST_LINK: begin
				wr.next_waddr = tail_q[EAW-1:0];
				wr.next_wdata = {1'b0, e_q};
				wr.head_wdata = {1'b0, e_q};
				if (tail_q[PW-1])
					wr.head_we = 1'b1;
				else
					wr.next_we = 1'b1;
			end
			kcrt_pkg::ST_PCMP: begin
				wr.rank_we    = rank_rdata.count < ecount_q;
				wr.rank_waddr = p_q;
				wr.rank_wdata = rank_rdata;
				wr.pos_we     = rank_rdata.count < ecount_q;
				wr.pos_waddr  = rank_rdata.entry;
				wr.pos_wdata  = p_q;
			end
			kcrt_pkg::ST_PFIN: begin
				wr.rank_we          = 1'b1;
				wr.rank_waddr       = p_q;
				wr.rank_wdata.entry = e_q;
				wr.rank_wdata.count = ecount_q;
				wr.pos_we           = 1'b1;
				wr.pos_waddr        = e_q;
				wr.pos_wdata        = p_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kcrt_pkg::ST_INIT;
			sweep_q     <= '0;
			used_q      <= '0;
			top_limit_q <= 9'd10;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				top_limit_q <= cfg_data;
			if (state_q == kcrt_pkg::ST_INIT || state_q == kcrt_pkg::ST_CLEAR)
				sweep_q <= sweep_q + 1'b1;
			if (state_q == kcrt_pkg::ST_CLEAR)
				used_q <= '0;
			else if (state_q == kcrt_pkg::ST_LINK)
				used_q <= used_q + 1'b1;
			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			m_tdata_q <= {7'd0, rank_q, ent_q, st_q};
		unique case (state_q)
			kcrt_pkg::ST_IDLE: begin
				tid_q  <= s_tdata[32:2];
				bh_q   <= s_tdata[80:33] & kcrt_pkg::board_mask(0);
				bm_q   <= s_tdata[128:81] & kcrt_pkg::board_mask(1);
				bl_q   <= s_tdata[176:129] & kcrt_pkg::board_mask(2);
				cnt_q  <= s_tdata[192:177];
				tm_q   <= s_tdata[224:193];
				tag_q  <= s_tdata[240:225];
				ri_q   <= s_tdata[248:241];
				ent_q  <= '0;
				st_q   <= kcrt_pkg::STAT_OK;
				rank_q <= '0;
			end
			kcrt_pkg::ST_HEADW: begin
				cur_q   <= head_rdata;
				tail_q  <= kcrt_pkg::PTR_EMPTY;
				steps_q <= '0;
			end
			kcrt_pkg::ST_WALK:
				if (chain_end && table_full) st_q <= kcrt_pkg::STAT_FULL;
			kcrt_pkg::ST_CMP: begin
				if (match) begin
					ent_q    <= hit_ent;
					e_q      <= cur_q[EAW-1:0];
					ecount_q <= hit_ent.count;
					st_q     <= sum[32] ? kcrt_pkg::STAT_SAT : kcrt_pkg::STAT_OK;
				end else begin
					tail_q  <= cur_q;
					cur_q   <= next_rdata;
					steps_q <= steps_q + 1'b1;
				end
			end
			kcrt_pkg::ST_POSW: p_q <= pos_rdata;
			kcrt_pkg::ST_NEW: begin
				ent_q    <= new_ent;
				e_q      <= used_q[EAW-1:0];
				p_q      <= used_q[EAW-1:0];
				ecount_q <= {16'd0, cnt_q};
			end
			kcrt_pkg::ST_PCMP:
				if (rank_rdata.count < ecount_q) p_q <= p_q - 1'b1;
			kcrt_pkg::ST_PFIN: rank_q <= p_q;
			kcrt_pkg::ST_RCHK: begin
				rank_q <= ri_q;
				if (!read_ok) st_q <= kcrt_pkg::STAT_RANK;
			end
			kcrt_pkg::ST_RENT: ent_q <= entry_rdata;
			default: ;
		endcase
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= kcrt_pkg::PTR_EMPTY)
		else $error("entry count beyond table size");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("second item taken while one is in work");

	a_promote_up: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kcrt_pkg::ST_PCMP |=> p_q <= $past(p_q))
		else $error("promotion moved an entry down");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kcrt_pkg::ST_WALK && chain_end && table_full) |=> !wr.entry_we)
		else $error("full table still wrote an entry");

endmodule
`default_nettype wire

FILE: sv/kcrt_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none
module kcrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: verif/tb_keyed_count_ranking_table_core.sv
// Self-checking testbench for keyed_count_ranking_table_core.
// Uses kcrt_pkg for opcodes and status codes and keeps its own model of the
// hash chains and rank list.
`timescale 1ns / 1ps
module tb_keyed_count_ranking_table_core;

	typedef struct packed {
		logic [7:0]  rank;
		logic [15:0] tag;
		logic [31:0] tm;
		logic [15:0] cnt;
		logic [47:0] bl;
		logic [47:0] bm;
		logic [47:0] bh;
		logic [30:0] tid;
		kcrt_pkg::opcode_t op;
	} post_item_t;

	typedef struct packed {
		logic [7:0]  rk;
		logic [15:0] tag;
		logic [31:0] tm;
		logic [31:0] cnt;
		logic [47:0] bl;
		logic [47:0] bm;
		logic [47:0] bh;
		logic [30:0] tid;
		kcrt_pkg::status_t st;
	} rank_reply_t;

	typedef struct {
		post_item_t        it;
		bit                has_exp;
		kcrt_pkg::status_t exp_st;
		logic [7:0]        exp_rk;
	} script_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [255:0] s_tdata;	// opcode, thread_id, board high/mid/low, count, time, tag, rank
	logic         m_tvalid;
	logic         m_tready;
	logic [271:0] m_tdata;	// status, thread_id, board high/mid/low, count, time, tag, rank
	logic         cfg_valid;
	logic         cfg_ready;
	logic [8:0]   cfg_data;

	keyed_count_ranking_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// shadow table
	logic [30:0] tbl_thread [kcrt_pkg::TABLE_ENTRIES];
	logic [47:0] tbl_bh [kcrt_pkg::TABLE_ENTRIES];
	logic [47:0] tbl_bm [kcrt_pkg::TABLE_ENTRIES];
	logic [47:0] tbl_bl [kcrt_pkg::TABLE_ENTRIES];
	logic [31:0] tbl_count [kcrt_pkg::TABLE_ENTRIES];
	logic [31:0] tbl_time [kcrt_pkg::TABLE_ENTRIES];
	logic [15:0] tbl_tag [kcrt_pkg::TABLE_ENTRIES];
	int          tbl_next [kcrt_pkg::TABLE_ENTRIES];
	int          tbl_order [kcrt_pkg::TABLE_ENTRIES];
	int          bucket_first [kcrt_pkg::BUCKETS];
	int          tbl_used;
	int          rank_limit;

	rank_reply_t pending_replies [$];
	int          failures;
	int          n_adds, n_reads, n_sat, n_full, n_miss, n_clear;
	int          burst_left;
	bit          hold_req;

	function automatic int move_up(int p);
		int e;
		e = tbl_order[p];
		while (p > 0 && tbl_count[tbl_order[p-1]] < tbl_count[e]) begin
			tbl_order[p] = tbl_order[p-1];
			p--;
		end
		tbl_order[p] = e;
		return p;
	endfunction

	function automatic rank_reply_t fill_reply(kcrt_pkg::status_t st, int e, int pos);
		rank_reply_t r;
		r.st = st;
		r.tid = tbl_thread[e];
		r.bh = tbl_bh[e];
		r.bm = tbl_bm[e];
		r.bl = tbl_bl[e];
		r.cnt = tbl_count[e];
		r.tm = tbl_time[e];
		r.tag = tbl_tag[e];
		r.rk = pos[7:0];
		return r;
	endfunction

	// all 18 board bytes are significant, so keys compare on full words
	function automatic rank_reply_t table_apply(post_item_t it);
		rank_reply_t r;
		int cur, tail, steps, h, pos, e;
		logic [32:0] sum;
		r = '0;
		case (it.op)
			kcrt_pkg::OP_ADD: begin
				h = it.tid % kcrt_pkg::BUCKETS;
				cur = bucket_first[h];
				tail = -1;
				steps = 0;
				while (cur < kcrt_pkg::TABLE_ENTRIES && steps < kcrt_pkg::TABLE_ENTRIES) begin
					if (tbl_thread[cur] == it.tid && tbl_bh[cur] == it.bh &&
					    tbl_bm[cur] == it.bm && tbl_bl[cur] == it.bl) begin
						sum = tbl_count[cur] + it.cnt;
						r.st = kcrt_pkg::STAT_OK;
						if (sum > 33'hFFFF_FFFF) begin
							sum = 33'hFFFF_FFFF;
							r.st = kcrt_pkg::STAT_SAT;
						end
						tbl_count[cur] = sum[31:0];
						if (it.tm > tbl_time[cur])
							tbl_time[cur] = it.tm;
						pos = 0;
						for (int i = tbl_used - 1; i >= 0; i--)
							if (tbl_order[i] == cur)
								pos = i;
						pos = move_up(pos);
						return fill_reply(r.st, cur, pos);
					end
					tail = cur;
					cur = tbl_next[cur];
					steps++;
				end
				if (tbl_used >= kcrt_pkg::TABLE_ENTRIES) begin
					r.st = kcrt_pkg::STAT_FULL;
					return r;
				end
				e = tbl_used;
				tbl_thread[e] = it.tid;
				tbl_bh[e] = it.bh;
				tbl_bm[e] = it.bm;
				tbl_bl[e] = it.bl;
				tbl_count[e] = 32'(it.cnt);
				tbl_time[e] = it.tm;
				tbl_tag[e] = it.tag;
				tbl_next[e] = kcrt_pkg::TABLE_ENTRIES;
				if (tail >= 0)
					tbl_next[tail] = e;
				else
					bucket_first[h] = e;
				tbl_order[e] = e;
				tbl_used = e + 1;
				pos = move_up(e);
				return fill_reply(kcrt_pkg::STAT_OK, e, pos);
			end
			kcrt_pkg::OP_READ: begin
				if (it.rank < rank_limit && it.rank < tbl_used)
					return fill_reply(kcrt_pkg::STAT_OK, tbl_order[it.rank], it.rank);
				r.st = kcrt_pkg::STAT_RANK;
				r.rk = it.rank;
			end
			kcrt_pkg::OP_CLEAR: begin
				foreach (bucket_first[i])
					bucket_first[i] = kcrt_pkg::TABLE_ENTRIES;
				tbl_used = 0;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic post_item_t mk_item(kcrt_pkg::opcode_t op, logic [30:0] tid,
			logic [47:0] bh, logic [47:0] bm, logic [47:0] bl, logic [15:0] cnt,
			logic [31:0] tm, logic [15:0] tag, logic [7:0] rank);
		post_item_t it;
		it.op = op; it.tid = tid; it.bh = bh; it.bm = bm; it.bl = bl;
		it.cnt = cnt; it.tm = tm; it.tag = tag; it.rank = rank;
		return it;
	endfunction

	function automatic logic [47:0] rand48();
		return {$urandom(), $urandom()};
	endfunction

	task automatic note_field(string name, logic [47:0] e, logic [47:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %0h, got %0h", name, e, a);
			failures++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		rank_reply_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[264:0];
			if (pending_replies.size() == 0) begin
				$error("result word with nothing pending: %0h", got);
				failures++;
			end else begin
				want = pending_replies.pop_front();
				note_field("status", want.st, got.st);
				note_field("out_thread_id", want.tid, got.tid);
				note_field("out_board_high", want.bh, got.bh);
				note_field("out_board_mid", want.bm, got.bm);
				note_field("out_board_low", want.bl, got.bl);
				note_field("out_count", want.cnt, got.cnt);
				note_field("out_time", want.tm, got.tm);
				note_field("out_tag", want.tag, got.tag);
				note_field("out_rank", want.rk, got.rk);
				if (got.st == kcrt_pkg::STAT_SAT) n_sat++;
				if (got.st == kcrt_pkg::STAT_FULL) n_full++;
				if (got.st == kcrt_pkg::STAT_RANK) n_miss++;
			end
		end
	end

	// receiver: own stall pattern, plus one long hold-off on request
	initial begin
		int hold_left;
		logic [15:0] pat;
		hold_left = 0;
		pat = 16'hFFFF;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= pat[0];
				pat = {pat[0], pat[15:1]};
				if ($urandom_range(0, 31) == 0)
					pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
			end
		end
	end

	task automatic send_item(post_item_t it);
		rank_reply_t want;
		if (burst_left <= 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, it};
		do @(posedge clk); while (!s_tready);
		want = table_apply(it);
		pending_replies.push_back(want);
		case (it.op)
			kcrt_pkg::OP_ADD:   n_adds++;
			kcrt_pkg::OP_READ:  n_reads++;
			kcrt_pkg::OP_CLEAR: n_clear++;
			default: ;
		endcase
	endtask

	// let all results arrive, then wait with the input idle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (2200) @(posedge clk);
	endtask

	task automatic write_limit(int v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= 9'(v);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		rank_limit = v;
	endtask

	function automatic post_item_t random_item(ref post_item_t pool [16]);
		post_item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it = mk_item(kcrt_pkg::OP_ADD, 31'($urandom()), rand48(), rand48(), rand48(),
			16'($urandom()), $urandom(), 16'($urandom()), 8'($urandom()));
		if (pick < 56) begin
			it = pool[$urandom_range(0, 15)];
			it.cnt = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 9));
			it.tm = $urandom();
			it.tag = 16'($urandom());
		end else if (pick < 70) begin
			it.op = kcrt_pkg::OP_ADD;
		end else if (pick < 92) begin
			it.op = kcrt_pkg::OP_READ;
			it.rank = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 24));
		end else if (pick < 93) begin
			it.op = kcrt_pkg::OP_CLEAR;
		end else begin
			it.op = kcrt_pkg::OP_NONE;
		end
		return it;
	endfunction

	script_row_t script [$];
	post_item_t  key_pool [16];

	initial begin
		rank_reply_t chk;
		post_item_t it;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_req = 1'b0;
		burst_left = 0;
		failures = 0;
		n_adds = 0; n_reads = 0; n_sat = 0; n_full = 0; n_miss = 0; n_clear = 0;
		rank_limit = 10;
		tbl_used = 0;
		foreach (bucket_first[i])
			bucket_first[i] = kcrt_pkg::TABLE_ENTRIES;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed part
		script.push_back('{mk_item(kcrt_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0),
			1, kcrt_pkg::STAT_RANK, 0});
		script.push_back('{mk_item(kcrt_pkg::OP_NONE, '1, '1, '1, '1, '1, '1, '1, '1),
			1, kcrt_pkg::STAT_OK, 0});
		script.push_back('{mk_item(kcrt_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0),
			1, kcrt_pkg::STAT_OK, 0});
		script.push_back('{mk_item(kcrt_pkg::OP_ADD, '1, '1, '1, '1, '1, '1, '1, 0),
			1, kcrt_pkg::STAT_OK, 0});
		// same bucket as thread 0, walks the chain
		script.push_back('{mk_item(kcrt_pkg::OP_ADD, 2048, 0, 0, 0, 5, 100, 16'h11, 0),
			0, kcrt_pkg::STAT_OK, 0});
		// hit with equal date, then with an earlier date
		script.push_back('{mk_item(kcrt_pkg::OP_ADD, 0, 0, 0, 0, 3, 0, 16'h22, 0),
			0, kcrt_pkg::STAT_OK, 0});
		script.push_back('{mk_item(kcrt_pkg::OP_ADD, 2048, 0, 0, 0, 4, 50, 16'h33, 0),
			0, kcrt_pkg::STAT_OK, 0});
		// keys differing only after a zero byte or in the last byte
		script.push_back('{mk_item(kcrt_pkg::OP_ADD, 0, 48'h41_00_42_00_00_00, 0, 0, 7, 9, 1, 0),
			0, kcrt_pkg::STAT_OK, 0});
		script.push_back('{mk_item(kcrt_pkg::OP_ADD, 0, 48'h41_00_00_00_00_00, 0, 0, 7, 9, 2, 0),
			0, kcrt_pkg::STAT_OK, 0});
		script.push_back('{mk_item(kcrt_pkg::OP_ADD, 0, 0, 0, 48'h1, 1, 1, 3, 0),
			0, kcrt_pkg::STAT_OK, 0});
		for (int r = 0; r < 7; r++)
			script.push_back('{mk_item(kcrt_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 8'(r)),
				0, kcrt_pkg::STAT_OK, 0});
		script.push_back('{mk_item(kcrt_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 255),
			1, kcrt_pkg::STAT_RANK, 255});
		script.push_back('{mk_item(kcrt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0),
			1, kcrt_pkg::STAT_OK, 0});
		script.push_back('{mk_item(kcrt_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0),
			1, kcrt_pkg::STAT_RANK, 0});
		foreach (script[i]) begin
			send_item(script[i].it);
			chk = pending_replies[$];
			if (script[i].has_exp && (chk.st !== script[i].exp_st ||
			    chk.rk !== script[i].exp_rk)) begin
				$error("row %0d: status/rank expected %0d/%0d, predicted %0d/%0d",
					i, script[i].exp_st, script[i].exp_rk, chk.st, chk.rk);
				failures++;
			end
		end
		drain();

		// full table, long chains in two buckets
		write_limit(256);
		for (int i = 0; i < 256; i++)
			send_item(mk_item(kcrt_pkg::OP_ADD, 31'(i * 1024), rand48(), 0, 0,
				16'($urandom_range(0, 40)), $urandom(), 16'(i), 0));
		for (int i = 0; i < 4; i++)
			send_item(mk_item(kcrt_pkg::OP_ADD, 31'($urandom()), rand48(), 0, 0, 1, 1, 1, 0));
		send_item(mk_item(kcrt_pkg::OP_ADD, 0, tbl_bh[0], 0, 0, 9, 9, 9, 0));
		send_item(mk_item(kcrt_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 255));
		send_item(mk_item(kcrt_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk_item(kcrt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		drain();

		// random: pool of keys, the even ones and key 15 sharing one bucket
		for (int k = 0; k < 16; k++) begin
			key_pool[k] = mk_item(kcrt_pkg::OP_ADD, 31'($urandom()), rand48(), rand48(),
				rand48(), 0, 0, 0, 0);
			if (k % 2 == 0)
				key_pool[k].tid = 31'(300 + 2048 * $urandom_range(0, 1000));
		end
		key_pool[15] = key_pool[14];
		key_pool[15].bl[0] = ~key_pool[15].bl[0];
		write_limit(1);
		for (int n = 0; n < 220; n++) begin
			if (n == 75) begin
				drain();
				write_limit($urandom_range(2, 30));
			end
			if (n == 110)
				hold_req = 1'b1;
			if (n == 150) begin
				drain();
				write_limit(10);
			end
			it = random_item(key_pool);
			send_item(it);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("adds %0d, reads %0d, clears %0d; saturated %0d, dropped %0d, rank misses %0d",
			n_adds, n_reads, n_clear, n_sat, n_full, n_miss);
		$display("limits 1, 256 and mid values; full table, chain walks, opcode 3 covered");
		if (failures == 0)
			$display("keyed_count_ranking_table_core verification clean");
		else
			$display("keyed_count_ranking_table_core verification failed");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("keyed_count_ranking_table_core verification failed");
		$finish;
	end

endmodule
